// File: sv/dmc_pkg.sv
// Shared types and constants for the density-matrix-from-coefficients block.
// No dependencies; compiled first.
package dmc_pkg;

  localparam int ROW_W    = 8;
  localparam int ORB_W    = 6;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int DENS_W   = 48;
  localparam int NROWS_W  = 9;
  localparam int NOCC_W   = 7;
  localparam int CFG_W    = 16;

  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 9'd256;
  localparam logic [NOCC_W-1:0]  NUM_OCC_RST  = 7'd0;

  typedef enum logic {CMD_WRITE = 1'b0, CMD_READ = 1'b1} cmd_t;
  typedef enum logic {STAT_OK = 1'b0, STAT_RANGE = 1'b1} status_t;
  typedef enum logic {REG_NUM_ROWS = 1'b0, REG_NUM_OCC = 1'b1} reg_idx_t;
  typedef enum logic {ST_IDLE, ST_RUN} state_t;

endpackage

// File: sv/dmc_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on dmc_pkg.
interface dmc_req_if;
  import dmc_pkg::*;
  logic                     valid;
  logic                     ready;
  cmd_t                     command;
  logic [ROW_W-1:0]         row_a;
  logic [ROW_W-1:0]         row_b;
  logic [ORB_W-1:0]         orbital;
  logic signed [COEF_W-1:0] coefficient;
  modport source (output valid, command, row_a, row_b, orbital, coefficient, input ready);
  modport sink   (input valid, command, row_a, row_b, orbital, coefficient, output ready);
endinterface

interface dmc_rsp_if;
  import dmc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DENS_W-1:0] density;
  status_t                  status;
  modport source (output valid, density, status, input ready);
  modport sink   (input valid, density, status, output ready);
endinterface

interface dmc_cfg_if;
  import dmc_pkg::*;
  logic             valid;
  logic             ready;
  reg_idx_t         index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/density_matrix_from_coefficients.sv
// Closed-shell density matrix entry from a stored orbital coefficient matrix.
// Depends on dmc_pkg and the channel interfaces in dmc_if.sv.
//
// Usage:
//   req  - one request per command. A write stores one Q3.14 coefficient at
//          (row_a, orbital); a read returns the density entry for rows
//          row_a and row_b (either order).
//   rsp  - exactly one response per request: density (28 fractional bits)
//          and status. Writes and range errors answer with density zero.
//   cfg  - register writes (num_rows, num_occupied), always ready; write
//          only while no request is in flight.
// Timing:
//   Writes and rejected requests: the response is registered in the cycle
//   after acceptance. Reads: occ = min(num_occupied, MAX_OCC) coefficient
//   pairs summed, one pair per cycle through a single multiply-accumulate
//   unit fed by a two-read-port coefficient memory.
//   One request is processed at a time.
// Reset: clears control and registers to num_rows 256, num_occupied 0. The
//   coefficient memory is not cleared; read only entries already written.
// Stall: the response sits in an output register; a new request is taken
//   in the cycle that register is emptied.
module density_matrix_from_coefficients #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_OCC  = 64
) (
  input  logic      clk,
  input  logic      rst,
  dmc_req_if.sink   req,
  dmc_rsp_if.source rsp,
  dmc_cfg_if.sink   cfg
);
  import dmc_pkg::*;

  // only rows < 256 and orbitals < 64 are addressable by the request fields
  localparam int ROW_N   = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int OCC_N   = (MAX_OCC < 64) ? MAX_OCC : 64;
  localparam int RW      = (ROW_N > 1) ? $clog2(ROW_N) : 1;
  localparam int OW      = (OCC_N > 1) ? $clog2(OCC_N) : 1;
  localparam int AW      = RW + OW;
  localparam int DEPTH   = ROW_N * (2 ** OW);
  localparam int OCC_CAP = (MAX_OCC > 127) ? 127 : MAX_OCC;

  logic [NROWS_W-1:0] num_rows;
  logic [NOCC_W-1:0]  num_occupied;

  state_t state, state_next;

  logic signed [COEF_W-1:0] mem [DEPTH];
  logic signed [COEF_W-1:0] rd_a, rd_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DENS_W-1:0] acc, prod_ext, prod_scaled;

  logic [NOCC_W-1:0] k, occ;
  logic [RW-1:0]     row_a_q, row_b_q;
  logic              diag;
  logic              rd_v, prod_v;

  logic              rsp_valid;
  logic signed [DENS_W-1:0] rsp_density;
  status_t           rsp_status;

  logic    row_a_ok, row_b_ok, orb_ok;
  logic    accept, wr_en, start, imm, issue, finish;
  status_t imm_status;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [NOCC_W-1:0] occ_clamped;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows     <= NUM_ROWS_RST;
      num_occupied <= NUM_OCC_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_NUM_ROWS: num_rows     <= cfg.data[NROWS_W-1:0];
        REG_NUM_OCC:  num_occupied <= cfg.data[NOCC_W-1:0];
      endcase
    end
  end

  // request decode
  assign row_a_ok = ({1'b0, req.row_a} < num_rows) && (32'(req.row_a) < MAX_ROWS);
  assign row_b_ok = ({1'b0, req.row_b} < num_rows) && (32'(req.row_b) < MAX_ROWS);
  assign orb_ok   = 32'(req.orbital) < MAX_OCC;

  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign wr_en     = accept && (req.command == CMD_WRITE) && row_a_ok && orb_ok;
  assign start     = accept && (req.command == CMD_READ) && row_a_ok && row_b_ok;
  assign imm       = accept && !start;
  assign imm_status = (req.command == CMD_WRITE && row_a_ok && orb_ok) ? STAT_OK : STAT_RANGE;

  assign occ_clamped = (32'(num_occupied) > OCC_CAP) ? NOCC_W'(OCC_CAP) : num_occupied;

  assign issue  = (state == ST_RUN) && (k != occ);
  assign finish = (state == ST_RUN) && !issue && !rd_v && !prod_v;

  // coefficient memory: one write port, two registered read ports
  assign waddr   = {req.row_a[RW-1:0], req.orbital[OW-1:0]};
  assign raddr_a = {row_a_q, k[OW-1:0]};
  assign raddr_b = {row_b_q, k[OW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= req.coefficient;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_RUN;
      ST_RUN:  if (finish) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
      k      <= '0;
    end else begin
      rd_v   <= issue;
      prod_v <= rd_v;
      if (start) begin
        k <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
    end
  end

  // diagonal entries weigh 2, off-diagonal 4
  assign prod_ext    = DENS_W'(prod);
  assign prod_scaled = diag ? (prod_ext <<< 1) : (prod_ext <<< 2);

  always_ff @(posedge clk) begin
    if (start) begin
      occ     <= occ_clamped;
      row_a_q <= req.row_a[RW-1:0];
      row_b_q <= req.row_b[RW-1:0];
      diag    <= (req.row_a == req.row_b);
      acc     <= '0;
    end else if (prod_v) begin
      acc <= acc + prod_scaled;
    end
    prod <= rd_a * rd_b;
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (imm || finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm) begin
      rsp_density <= '0;
      rsp_status  <= imm_status;
    end else if (finish) begin
      rsp_density <= acc;
      rsp_status  <= STAT_OK;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.density = rsp_density;
  assign rsp.status  = rsp_status;

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == ST_IDLE)
    else $error("request ready outside idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == STAT_RANGE) |-> rsp_density == '0)
    else $error("range error with nonzero density");

  a_pipe_run: assert property (@(posedge clk) disable iff (rst)
    (rd_v || prod_v) |-> state == ST_RUN)
    else $error("accumulate pipeline busy outside run");

  a_finish_rsp: assert property (@(posedge clk) disable iff (rst)
    finish |=> rsp_valid && state == ST_IDLE)
    else $error("finished read without response");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> k <= occ)
    else $error("orbital counter past occupied count");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for density_matrix_from_coefficients: coefficient writes and
// density reads under random idling and stalls, checked against an in-bench predictor.
// Depends on dmc_pkg, the channel interfaces in dmc_if.sv and the block itself.
module tb_top;
  import dmc_pkg::*;

  class density_predictor #(int ROWS = 256, int OCC = 64);
    typedef struct packed {
      logic signed [DENS_W-1:0] density;
      status_t                  status;
    } entry_t;

    logic signed [COEF_W-1:0] coef_mem [ROWS*OCC];
    bit                       loaded [ROWS*OCC];
    int                       lead [ROWS];  // leading orbitals written, per row
    int                       n_rows;
    int                       n_occ;
    entry_t                   expected_entries [$];
    int                       errors;

    function new();
      n_rows = int'(NUM_ROWS_RST);
      n_occ  = int'(NUM_OCC_RST);
      errors = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      foreach (lead[i]) lead[i] = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
      if (idx == REG_NUM_ROWS) n_rows = int'(data[NROWS_W-1:0]);
      else n_occ = int'(data[NOCC_W-1:0]);
    endfunction

    function bit row_ok(int row);
      return row < n_rows && row < ROWS;
    endfunction

    function int occ_used();
      return (n_occ > OCC) ? OCC : n_occ;
    endfunction

    // a row may be read only once every summed orbital of it holds a value
    function bit row_ready(int row);
      return row_ok(row) && lead[row] >= occ_used();
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction

    function void take_request(cmd_t cmd, int ra, int rb, int orb,
                               logic signed [COEF_W-1:0] coef);
      entry_t                   e;
      longint                   acc;
      longint                   scale;
      int                       k;
      logic signed [COEF_W-1:0] ca;
      logic signed [COEF_W-1:0] cb;
      acc = 0;
      e.status = STAT_OK;
      if (cmd == CMD_WRITE) begin
        if (row_ok(ra) && orb < OCC) begin
          coef_mem[ra*OCC + orb] = coef;
          loaded[ra*OCC + orb] = 1'b1;
          while (lead[ra] < OCC && loaded[ra*OCC + lead[ra]]) lead[ra]++;
        end else begin
          e.status = STAT_RANGE;
        end
      end else if (!row_ok(ra) || !row_ok(rb)) begin
        e.status = STAT_RANGE;
      end else begin
        scale = (ra == rb) ? 2 : 4;
        for (k = 0; k < occ_used(); k++) begin
          ca = coef_mem[ra*OCC + k];
          cb = coef_mem[rb*OCC + k];
          acc += scale * (longint'(ca) * longint'(cb));
        end
      end
      e.density = acc[DENS_W-1:0];
      expected_entries.push_back(e);
    endfunction

    function void check_response(logic signed [DENS_W-1:0] density, status_t status);
      entry_t e;
      if (expected_entries.size() == 0) begin
        errors++;
        $display("%0t: response with nothing pending: density %h status %0d",
                 $time, density, status);
        return;
      end
      e = expected_entries.pop_front();
      if (status !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, status);
      end
      if (density !== e.density) begin
        errors++;
        $display("%0t: density mismatch: expected %h actual %h", $time, e.density, density);
      end
    endfunction
  endclass

  localparam int TB_ROWS      = 256;
  localparam int TB_OCC       = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   hold_len;
  int   hold_left;
  int   cycle_count;
  int   sent;

  density_predictor #(TB_ROWS, TB_OCC) pred;

  dmc_req_if req_ch();
  dmc_rsp_if rsp_ch();
  dmc_cfg_if cfg_ch();

  density_matrix_from_coefficients #(
    .MAX_ROWS(TB_ROWS),
    .MAX_OCC (TB_OCC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // response side: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left > 0) begin
      rsp_ch.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      pred.check_response(rsp_ch.density, rsp_ch.status);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_request(cmd_t cmd, int ra, int rb, int orb,
                              logic signed [COEF_W-1:0] coef);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.valid       = 1'b1;
    req_ch.command     = cmd;
    req_ch.row_a       = ra[ROW_W-1:0];
    req_ch.row_b       = rb[ROW_W-1:0];
    req_ch.orbital     = orb[ORB_W-1:0];
    req_ch.coefficient = coef;
    do @(posedge clk); while (!req_ch.ready);
    pred.take_request(cmd, ra, rb, orb, coef);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pred.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    pred.set_reg(idx, value[CFG_W-1:0]);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      3:       return '1;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic int pick_ready_row();
    int rows_ready [$];
    for (int r = 0; r < TB_ROWS; r++)
      if (pred.row_ready(r)) rows_ready.push_back(r);
    if (rows_ready.size() == 0) return -1;
    return rows_ready[$urandom_range(0, rows_ready.size() - 1)];
  endfunction

  task automatic fill_row(int row);
    for (int k = 0; k < pred.occ_used(); k++)
      send_request(CMD_WRITE, row, $urandom_range(0, 255), k, rand_coef());
  endtask

  task automatic random_item();
    int r;
    int ra;
    int rb;
    int top;
    int tmp;
    top = (pred.n_rows < TB_ROWS) ? pred.n_rows : TB_ROWS;
    r = $urandom_range(0, 99);
    ra = pick_ready_row();
    rb = pick_ready_row();
    if (top == 0 || r >= 88) begin
      if (top < TB_ROWS && $urandom_range(0, 1) == 1) begin
        // read with at least one row past the limit
        ra = $urandom_range(top, TB_ROWS - 1);
        rb = $urandom_range(0, TB_ROWS - 1);
        if ($urandom_range(0, 1) == 1) begin
          tmp = ra;
          ra = rb;
          rb = tmp;
        end
        send_request(CMD_READ, ra, rb, $urandom_range(0, 63), rand_coef());
      end else begin
        send_request(CMD_WRITE, $urandom_range(0, TB_ROWS - 1), $urandom_range(0, 255),
                     $urandom_range(0, 63), rand_coef());
      end
    end else if (r < 20 || ra < 0) begin
      if ($urandom_range(0, 1) == 1) begin
        ra = $urandom_range(0, top - 1);
      end else begin
        ra = $urandom_range(0, 4);
        if (ra == 4 || ra >= top) ra = top - 1;
      end
      if (pred.occ_used() == 0)
        send_request(CMD_WRITE, ra, $urandom_range(0, 255), $urandom_range(0, 63),
                     rand_coef());
      else
        fill_row(ra);
    end else begin
      if ($urandom_range(0, 3) == 0) rb = ra;
      send_request(CMD_READ, ra, rb, $urandom_range(0, 63), rand_coef());
    end
  endtask

  task automatic run_phase(int rows, int occ, int idle, int stall, int count,
                           bit pause_mid, int hold);
    int start;
    bit paused;
    bit held;
    drain();
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_NUM_OCC, occ);
    idle_pct = idle;
    stall_pct = stall;
    start = sent;
    paused = 1'b0;
    held = 1'b0;
    while (sent - start < count) begin
      if (pause_mid && !paused && sent - start >= count / 2) begin
        paused = 1'b1;
        drain();
      end
      if (hold > 0 && !held && sent - start >= count / 3) begin
        held = 1'b1;
        hold_len = hold;
      end
      random_item();
    end
  endtask

  initial begin
    pred = new();
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_WRITE;
    req_ch.row_a       = '0;
    req_ch.row_b       = '0;
    req_ch.orbital     = '0;
    req_ch.coefficient = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_NUM_ROWS;
    cfg_ch.data        = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_len  = 0;
    hold_left = 0;
    sent      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: nothing summed, so any rows read as zero
    send_request(CMD_READ, 3, 250, 0, '0);
    drain();
    write_reg(REG_NUM_ROWS, 200);
    write_reg(REG_NUM_OCC, 3);
    send_request(CMD_WRITE, 0, 0, 0, COEF_MAX);
    send_request(CMD_WRITE, 0, 255, 1, COEF_MIN);
    send_request(CMD_WRITE, 0, 17, 2, 18'sd1);
    send_request(CMD_WRITE, 199, 0, 0, COEF_MIN);
    send_request(CMD_WRITE, 199, 0, 1, COEF_MIN);
    send_request(CMD_WRITE, 199, 0, 2, COEF_MAX);
    send_request(CMD_READ, 0, 199, 0, '0);
    send_request(CMD_READ, 199, 0, 63, '1);
    send_request(CMD_READ, 0, 0, 0, '0);
    send_request(CMD_READ, 199, 199, 0, '0);
    // rejected writes past the row limit leave the store alone; orbital 63 is not summed
    send_request(CMD_WRITE, 200, 0, 0, COEF_MAX);
    send_request(CMD_WRITE, 255, 255, 63, '1);
    send_request(CMD_WRITE, 7, 0, 63, 18'sd5);
    send_request(CMD_READ, 0, 255, 0, '0);
    send_request(CMD_READ, 255, 0, 0, '0);
    send_request(CMD_READ, 200, 200, 0, '0);
    send_request(CMD_READ, 199, 0, 0, '0);

    run_phase(256, 8, 0, 0, 100, 1'b1, 0);
    run_phase(256, 64, 73, 0, 130, 1'b0, 0);
    run_phase(40, 127, 0, 73, 90, 1'b0, 0);
    run_phase(1, 5, 25, 25, 50, 1'b0, 0);
    run_phase(0, 3, 0, 0, 20, 1'b0, 0);
    run_phase(511, 1, 73, 73, 60, 1'b0, 0);
    run_phase(256, 16, 25, 25, 100, 1'b0, 400);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pred.errors == 0 && pred.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: filelist.f
sv/dmc_pkg.sv
sv/dmc_if.sv
sv/density_matrix_from_coefficients.sv
bench/tb_top.sv
